@@ src/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV pixel unit - shared package
// Default channel width, divider headroom and the hue sector offsets.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    // Default width of one colour channel code
    localparam int COLOR_BITS_DEF = 16;

    // Extra bits the hue divisor (six times the chroma) needs over a channel
    localparam int HUE_EXTRA_BITS = 3;

    // Width of the hue sector offset code
    localparam int OFF_BITS = 3;

    // Hue sector offsets, in sixths of a turn
    localparam logic [OFF_BITS-1:0] OFF_RED      = 3'd0;
    localparam logic [OFF_BITS-1:0] OFF_GREEN    = 3'd2;
    localparam logic [OFF_BITS-1:0] OFF_BLUE     = 3'd4;
    localparam logic [OFF_BITS-1:0] OFF_RED_WRAP = 3'd6;

endpackage

@@ src/rgbhsv_rgb_if.sv @@
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel that carries one RGB pixel per item.
// ----------------------------------------------------------------------------
interface rgbhsv_rgb_if #(
    parameter int COLOR_BITS = rgbhsv_pkg::COLOR_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ src/rgbhsv_hsv_if.sv @@
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid/ready channel that carries one HSV pixel per item.
// ----------------------------------------------------------------------------
interface rgbhsv_hsv_if #(
    parameter int COLOR_BITS = rgbhsv_pkg::COLOR_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

@@ src/rgbhsv_div_step.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV pixel unit - divider step
// One registered restoring step of both the hue and the saturation division.
// ----------------------------------------------------------------------------
module rgbhsv_div_step #(
    parameter int COLOR_BITS = rgbhsv_pkg::COLOR_BITS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_valid,
    output logic                                                o_ready,
    output logic                                                o_valid,
    input  logic                                                i_ready,
    input  logic [COLOR_BITS+rgbhsv_pkg::HUE_EXTRA_BITS-1:0]    i_hrem,
    input  logic [COLOR_BITS+rgbhsv_pkg::HUE_EXTRA_BITS-1:0]    i_hdiv,
    input  logic [COLOR_BITS-1:0]                               i_hquo,
    input  logic [COLOR_BITS-1:0]                               i_srem,
    input  logic [COLOR_BITS-1:0]                               i_squo,
    input  logic [COLOR_BITS-1:0]                               i_val,
    input  logic                                                i_grey,
    output logic [COLOR_BITS+rgbhsv_pkg::HUE_EXTRA_BITS-1:0]    o_hrem,
    output logic [COLOR_BITS+rgbhsv_pkg::HUE_EXTRA_BITS-1:0]    o_hdiv,
    output logic [COLOR_BITS-1:0]                               o_hquo,
    output logic [COLOR_BITS-1:0]                               o_srem,
    output logic [COLOR_BITS-1:0]                               o_squo,
    output logic [COLOR_BITS-1:0]                               o_val,
    output logic                                                o_grey
);
    import rgbhsv_pkg::*;

    localparam int HW = COLOR_BITS + HUE_EXTRA_BITS;

    logic            r_valid;
    logic [HW-1:0]   r_hrem;
    logic [HW-1:0]   r_hdiv;
    logic [COLOR_BITS-1:0] r_hquo;
    logic [COLOR_BITS-1:0] r_srem;
    logic [COLOR_BITS-1:0] r_squo;
    logic [COLOR_BITS-1:0] r_val;
    logic            r_grey;

    logic [HW:0]           h_shift;
    logic [HW:0]           h_diff;
    logic                  h_bit;
    logic [COLOR_BITS:0]   s_shift;
    logic [COLOR_BITS:0]   s_diff;
    logic                  s_bit;
    logic [HW-1:0]         n_hrem;
    logic [COLOR_BITS-1:0] n_hquo;
    logic [COLOR_BITS-1:0] n_srem;
    logic [COLOR_BITS-1:0] n_squo;

    // Hue: numerator bits below the remainder are all zero
    assign h_shift = {i_hrem, 1'b0};
    assign h_diff  = h_shift - {1'b0, i_hdiv};
    assign h_bit   = (h_shift >= {1'b0, i_hdiv});
    assign n_hrem  = h_bit ? h_diff[HW-1:0] : h_shift[HW-1:0];
    assign n_hquo  = {i_hquo[COLOR_BITS-2:0], h_bit};

    // Saturation: low numerator bits leave the top of i_squo as quotient bits enter
    assign s_shift = {i_srem, i_squo[COLOR_BITS-1]};
    assign s_diff  = s_shift - {1'b0, i_val};
    assign s_bit   = (s_shift >= {1'b0, i_val});
    assign n_srem  = s_bit ? s_diff[COLOR_BITS-1:0] : s_shift[COLOR_BITS-1:0];
    assign n_squo  = {i_squo[COLOR_BITS-2:0], s_bit};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hrem <= n_hrem;
            r_hdiv <= i_hdiv;
            r_hquo <= n_hquo;
            r_srem <= n_srem;
            r_squo <= n_squo;
            r_val  <= i_val;
            r_grey <= i_grey;
        end
    end

    assign o_valid = r_valid;
    assign o_hrem  = r_hrem;
    assign o_hdiv  = r_hdiv;
    assign o_hquo  = r_hquo;
    assign o_srem  = r_srem;
    assign o_squo  = r_squo;
    assign o_val   = r_val;
    assign o_grey  = r_grey;

endmodule

@@ src/rgb_to_hsv_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV pixel unit
// Converts RGB pixels to hue, saturation and brightness in a deep pipeline.
//
//   Channel   Dir  Handshake      Payload
//   i_pix     in   valid/ready    red, green, blue         (COLOR_BITS each)
//   o_pix     out  valid/ready    hue, saturation, brightness (COLOR_BITS each)
//
// One pixel per clock while the output is not stalled; stages in order: max/min select,
// numerator setup, one restoring divider step per quotient bit, output register.
// Reset is synchronous and clears only the valid bits.
// Each stage holds while its successor is full and stalled; empty stages still
// fill, so the input keeps accepting while a result waits at the output.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_unit #(
    parameter int COLOR_BITS = rgbhsv_pkg::COLOR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbhsv_rgb_if.sink    i_pix,
    rgbhsv_hsv_if.source  o_pix
);
    import rgbhsv_pkg::*;

    localparam int W  = COLOR_BITS;
    localparam int HW = COLOR_BITS + HUE_EXTRA_BITS;

    // ---------------- stage 1: largest, smallest, sector ----------------
    logic                r1_valid;
    logic [W-1:0]        r1_val;
    logic [W-1:0]        r1_chroma;
    logic [W:0]          r1_num;
    logic [OFF_BITS-1:0] r1_off;
    logic                s1_ready;
    logic                s2_ready;

    logic                g_max;
    logic                red_ge_blue;
    logic [W-1:0]        n_val;
    logic [W-1:0]        n_min;
    logic [W:0]          n_num;
    logic [OFF_BITS-1:0] n_off;

    assign g_max       = (i_pix.green >= i_pix.red) && (i_pix.green >= i_pix.blue);
    assign red_ge_blue = (i_pix.red >= i_pix.blue);

    always_comb begin
        n_num = {1'b0, i_pix.red} - {1'b0, i_pix.green};
        n_off = OFF_BLUE;
        n_val = i_pix.blue;
        if (g_max) begin
            n_val = i_pix.green;
            n_num = {1'b0, i_pix.blue} - {1'b0, i_pix.red};
            n_off = OFF_GREEN;
        end else if (red_ge_blue) begin
            n_val = i_pix.red;
            n_num = {1'b0, i_pix.green} - {1'b0, i_pix.blue};
            // wrap into the last sixth of the turn
            n_off = n_num[W] ? OFF_RED_WRAP : OFF_RED;
        end
        if ((i_pix.red <= i_pix.green) && (i_pix.red <= i_pix.blue)) begin
            n_min = i_pix.red;
        end else if (i_pix.green <= i_pix.blue) begin
            n_min = i_pix.green;
        end else begin
            n_min = i_pix.blue;
        end
    end

    assign i_pix.ready = s1_ready;
    assign s1_ready    = !r1_valid || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_ready) begin
            r1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pix.valid) begin
            r1_val    <= n_val;
            r1_chroma <= n_val - n_min;
            r1_num    <= n_num;
            r1_off    <= n_off;
        end
    end

    // ---------------- stage 2: numerators and divisors ----------------
    logic [HW-1:0]   c_ext;
    logic [HW-1:0]   c_x2;
    logic [HW-1:0]   c_x4;
    logic [HW-1:0]   n_offc;
    logic [HW:0]     n_hsum;
    logic [HW-1:0]   n_hdiv;
    logic            n_grey;
    logic [W-1:0]    n_shi;
    logic [W-1:0]    n_slo;

    assign c_ext = {{(HW-W){1'b0}}, r1_chroma};
    assign c_x2  = {c_ext[HW-2:0], 1'b0};
    assign c_x4  = {c_ext[HW-3:0], 2'b0};

    always_comb begin
        case (r1_off)
            OFF_RED:      n_offc = '0;
            OFF_GREEN:    n_offc = c_x2;
            OFF_BLUE:     n_offc = c_x4;
            OFF_RED_WRAP: n_offc = c_x4 + c_x2;
            default:      n_offc = '0;
        endcase
    end

    // n = offset*chroma + num lies in [0, 6*chroma)
    assign n_hsum = {1'b0, n_offc} + {{(HW-W){r1_num[W]}}, r1_num};
    assign n_hdiv = c_x4 + c_x2;
    assign n_grey = (r1_chroma == '0);
    // chroma*(2^W-1) = (chroma-1)*2^W + (2^W-chroma)
    assign n_shi  = n_grey ? '0 : r1_chroma - {{(W-1){1'b0}}, 1'b1};
    assign n_slo  = ~r1_chroma + {{(W-1){1'b0}}, 1'b1};

    logic            st_valid [0:W];
    logic            st_ready [0:W];
    logic [HW-1:0]   st_hrem  [0:W];
    logic [HW-1:0]   st_hdiv  [0:W];
    logic [W-1:0]    st_hquo  [0:W];
    logic [W-1:0]    st_srem  [0:W];
    logic [W-1:0]    st_squo  [0:W];
    logic [W-1:0]    st_val   [0:W];
    logic            st_grey  [0:W];

    logic            r2_valid;
    logic [HW-1:0]   r2_hrem;
    logic [HW-1:0]   r2_hdiv;
    logic [W-1:0]    r2_srem;
    logic [W-1:0]    r2_squo;
    logic [W-1:0]    r2_val;
    logic            r2_grey;

    assign s2_ready = !r2_valid || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_ready) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r1_valid) begin
            r2_hrem <= n_hsum[HW-1:0];
            r2_hdiv <= n_hdiv;
            r2_srem <= n_shi;
            r2_squo <= n_slo;
            r2_val  <= r1_val;
            r2_grey <= n_grey;
        end
    end

    assign st_valid[0] = r2_valid;
    assign st_hrem[0]  = r2_hrem;
    assign st_hdiv[0]  = r2_hdiv;
    assign st_hquo[0]  = '0;
    assign st_srem[0]  = r2_srem;
    assign st_squo[0]  = r2_squo;
    assign st_val[0]   = r2_val;
    assign st_grey[0]  = r2_grey;

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar k = 1; k <= W; k++) begin : g_step
        rgbhsv_div_step #(
            .COLOR_BITS (COLOR_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[k-1]),
            .o_ready (st_ready[k-1]),
            .o_valid (st_valid[k]),
            .i_ready (st_ready[k]),
            .i_hrem  (st_hrem[k-1]),
            .i_hdiv  (st_hdiv[k-1]),
            .i_hquo  (st_hquo[k-1]),
            .i_srem  (st_srem[k-1]),
            .i_squo  (st_squo[k-1]),
            .i_val   (st_val[k-1]),
            .i_grey  (st_grey[k-1]),
            .o_hrem  (st_hrem[k]),
            .o_hdiv  (st_hdiv[k]),
            .o_hquo  (st_hquo[k]),
            .o_srem  (st_srem[k]),
            .o_squo  (st_squo[k]),
            .o_val   (st_val[k]),
            .o_grey  (st_grey[k])
        );
    end

    // ---------------- output register ----------------
    logic         r_out_valid;
    logic [W-1:0] r_hue;
    logic [W-1:0] r_sat;
    logic [W-1:0] r_bright;

    assign st_ready[W] = !r_out_valid || o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (st_ready[W]) begin
            r_out_valid <= st_valid[W];
        end
    end

    // drop the quotients of a grey pixel: both are zero
    always_ff @(posedge i_clk) begin
        if (st_ready[W] && st_valid[W]) begin
            r_hue    <= st_grey[W] ? '0 : st_hquo[W];
            r_sat    <= st_grey[W] ? '0 : st_squo[W];
            r_bright <= st_val[W];
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.hue        = r_hue;
    assign o_pix.saturation = r_sat;
    assign o_pix.brightness = r_bright;

    // ---------------- assertions ----------------
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && (o_pix.brightness == '0)) |->
            ((o_pix.saturation == '0) && (o_pix.hue == '0)))
        else $error("black pixel with non-zero hue or saturation");

    a_unsat_no_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && (o_pix.saturation == '0)) |-> (o_pix.hue == '0))
        else $error("zero saturation with non-zero hue");

    a_wrap_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && (r1_off == OFF_RED_WRAP)) |-> r1_num[W])
        else $error("wrapped red sector with non-negative difference");

    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !s2_ready) |=> (r1_valid && $stable(r1_chroma) && $stable(r1_num)))
        else $error("first stage changed while stalled");

endmodule
